@@ rtl/core/sjf_preemptive_scheduler_core_assert.svh @@
// Assertion macros for the SJF scheduler core
`ifndef SJF_PREEMPTIVE_SCHEDULER_CORE_ASSERT_SVH
`define SJF_PREEMPTIVE_SCHEDULER_CORE_ASSERT_SVH
// implication checked every clock outside reset
`define SJF_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// next-cycle implication
`define SJF_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

@@ rtl/core/sjfs_pkg.sv @@
// Package: types and constants for the SJF scheduler core
`default_nettype none
package sjfs_pkg;
    localparam int QueueDepth = 16;
    localparam int MaxCpus    = 8;
    localparam int QW         = $clog2(QueueDepth);
    localparam int CW         = $clog2(MaxCpus);
    localparam logic [23:0] SentinelQ = 24'(999 << 8);

    localparam logic [1:0] OP_ENQ = 2'd0;
    localparam logic [1:0] OP_SCH = 2'd1;
    localparam logic [1:0] OP_REL = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  pid;
        logic [15:0] last_burst;
        logic [23:0] predicted_burst;
        logic [2:0]  cpu;
        logic [15:0] elapsed;
    } t_req;

    typedef struct packed {
        logic        assigned_valid;
        logic [7:0]  assigned_pid;
        logic        preempted;
        logic [7:0]  preempted_pid;
        logic [23:0] chosen_prediction;
        logic        queue_full;
    } t_rsp;

    typedef struct packed {
        logic [7:0]  pid;
        logic [15:0] last;
        logic [23:0] pred;
    } t_entry;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SCAN, ST_SCAN_W, ST_DECIDE, ST_SHIFT_RD, ST_SHIFT_WR,
        ST_APPEND, ST_OUT
    } t_state;

    typedef struct packed {
        logic        we;
        logic [QW-1:0] waddr;
        t_entry      wdata;
        logic [QW-1:0] raddr;
    } t_memctl;
endpackage
`default_nettype wire

@@ rtl/core/sjf_preemptive_scheduler_core.sv @@
// Top level: SJF preemptive scheduler with ready-table memory
// Usage:
//   Request channel i_req/i_req_valid/o_req_stall, response channel
//   o_rsp/o_rsp_valid/i_rsp_stall; one response per request.
//   i_decay_weight_we/i_decay_weight write the weight (saturates at 256).
// Operation:
//   enqueue, release, unused op and schedule on an empty table go straight
//   to the output state. Schedule otherwise reads each of the N ready entries
//   from memory, registers its prediction and compares it; the response follows
//   when nothing is chosen or the running process stays. When a process is
//   assigned, every entry after the chosen one is moved down by a read and a
//   write state before the append state. One request is in work at a time.
// Reset: synchronous active low; ready count and running slots cleared,
//   weight 128. Table contents stay undefined until written.
// Stall: a response waits in the output register while i_rsp_stall is
//   high; o_req_stall stays high until the response is taken.
`default_nettype none
module sjf_preemptive_scheduler_core
    import sjfs_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_req       i_req,
    input  wire logic       i_req_valid,
    output logic            o_req_stall,
    output t_rsp            o_rsp,
    output logic            o_rsp_valid,
    input  wire logic       i_rsp_stall,
    input  wire logic       i_decay_weight_we,
    input  wire logic [8:0] i_decay_weight
);
    t_state r_st, n_st;
    t_req   r_req;
    logic [8:0] r_w;
    logic [QW:0] r_cnt, n_cnt;
    logic [QW:0] r_i, n_i;
    logic [QW-1:0] r_best, n_best;
    logic r_found, n_found;
    logic [23:0] r_min, n_min;
    logic [7:0] r_cpid, n_cpid;
    logic [MaxCpus-1:0] r_rv;
    logic [7:0]  r_rpid [MaxCpus];
    logic [23:0] r_rpred [MaxCpus];
    t_rsp r_rsp, n_rsp;
    logic r_ov;
    t_memctl mc;
    t_entry rd;
    logic [23:0] p;
    logic [23:0] used, rem;
    logic [CW-1:0] cidx;
    logic cok, acc, lastscan;

    assign acc = i_req_valid && !o_req_stall;
    assign o_req_stall = (r_st != ST_IDLE) || r_ov;
    assign o_rsp = r_rsp;
    assign o_rsp_valid = r_ov;
    assign cidx = r_req.cpu[CW-1:0];
    assign cok = (32'(r_req.cpu) < MaxCpus);

    sjfs_ready_ram u_ram (.i_clk(i_clk), .i_ctl(mc), .o_rdata(rd));
    sjfs_predict u_pred (.i_clk(i_clk), .i_w(r_w), .i_last(rd.last),
                         .i_pred(rd.pred), .o_p(p));

    always_comb begin
        used = {r_req.elapsed, 8'd0};
        rem = (r_rpred[cidx] >= used) ? r_rpred[cidx] - used : 24'd0;
    end

    assign lastscan = (r_i + 1'b1 >= r_cnt);

    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE: if (acc) n_st = (i_req.op == OP_SCH && r_cnt != '0) ? ST_SCAN : ST_OUT;
            ST_SCAN: n_st = ST_SCAN_W;
            ST_SCAN_W: n_st = ST_DECIDE;
            ST_DECIDE: begin
                if (!lastscan) n_st = ST_SCAN;
                else if (!n_found || (r_rv[cidx] && rem <= n_min)) n_st = ST_OUT;
                else n_st = ST_SHIFT_RD;
            end
            ST_SHIFT_RD: n_st = (r_i + 1'b1 < r_cnt) ? ST_SHIFT_WR : ST_APPEND;
            ST_SHIFT_WR: n_st = ST_SHIFT_RD;
            ST_APPEND: n_st = ST_OUT;
            ST_OUT: n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    always_comb begin
        n_cnt = r_cnt; n_i = r_i; n_best = r_best; n_found = r_found;
        n_min = r_min; n_cpid = r_cpid; n_rsp = r_rsp;
        mc = '0;
        mc.raddr = r_i[QW-1:0];
        case (r_st)
            ST_IDLE: begin
                n_i = '0; n_found = 1'b0; n_min = SentinelQ;
                if (acc) begin
                    n_rsp = '0;
                    if (i_req.op == OP_ENQ) begin
                        if (r_cnt >= (QW+1)'(QueueDepth)) begin
                            n_rsp.queue_full = 1'b1;
                        end else begin
                            mc.we = 1'b1;
                            mc.waddr = r_cnt[QW-1:0];
                            mc.wdata = '{i_req.pid, i_req.last_burst, i_req.predicted_burst};
                            n_cnt = r_cnt + 1'b1;
                        end
                    end
                end
            end
            ST_DECIDE: begin
                if (p < r_min) begin
                    n_min = p; n_best = r_i[QW-1:0]; n_found = 1'b1; n_cpid = rd.pid;
                end
                if (!lastscan) n_i = r_i + 1'b1;
                else n_i = (QW+1)'(n_best);
            end
            ST_SHIFT_RD: mc.raddr = QW'(r_i + 1'b1);
            ST_SHIFT_WR: begin
                mc.we = 1'b1; mc.waddr = r_i[QW-1:0]; mc.wdata = rd;
                n_i = r_i + 1'b1;
            end
            ST_APPEND: begin
                if (r_rv[cidx]) begin
                    mc.we = 1'b1; mc.waddr = QW'(r_cnt - 1'b1);
                    mc.wdata = '{r_rpid[cidx], r_req.elapsed, rem};
                    n_rsp.preempted = 1'b1; n_rsp.preempted_pid = r_rpid[cidx];
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_OUT: begin
                if (r_req.op == OP_SCH && cok && r_rv[cidx]) begin
                    n_rsp.assigned_valid = 1'b1;
                    n_rsp.assigned_pid = r_rpid[cidx];
                    n_rsp.chosen_prediction = r_rpred[cidx];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE; r_cnt <= '0; r_rv <= '0; r_ov <= 1'b0; r_w <= 9'd128;
        end else begin
            r_st <= n_st; r_cnt <= n_cnt;
            if (i_decay_weight_we) r_w <= i_decay_weight;
            if (r_ov && !i_rsp_stall) r_ov <= 1'b0;
            if (r_st == ST_OUT) begin
                r_ov <= 1'b1;
                if (r_req.op == OP_REL && cok) r_rv[cidx] <= 1'b0;
            end
            if (r_st == ST_APPEND) r_rv[cidx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) r_req <= i_req;
        r_i <= n_i; r_best <= n_best; r_found <= n_found; r_min <= n_min;
        r_cpid <= n_cpid;
        if (r_st == ST_APPEND) begin
            r_rpid[cidx] <= r_cpid; r_rpred[cidx] <= r_min;
        end
        r_rsp <= n_rsp;
    end

    `include "sjf_preemptive_scheduler_core_assert.svh"
    `SJF_ASSERT_IMPL(a_cnt_max, i_clk, i_rst_n, 1'b1, r_cnt <= (QW+1)'(QueueDepth))
    `SJF_ASSERT_NEXT(a_out_valid, i_clk, i_rst_n, r_st == ST_OUT, o_rsp_valid)
    `SJF_ASSERT_IMPL(a_no_acc_busy, i_clk, i_rst_n, r_st != ST_IDLE, o_req_stall)
endmodule
`default_nettype wire

@@ rtl/core/sjfs_ready_ram.sv @@
// Ready table memory, one write and one registered read port
`default_nettype none
module sjfs_ready_ram
    import sjfs_pkg::*;
(
    input  wire logic    i_clk,
    input  wire t_memctl i_ctl,
    output t_entry       o_rdata
);
    t_entry r_mem [QueueDepth];
    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_ctl.waddr] <= i_ctl.wdata;
        end
        o_rdata <= r_mem[i_ctl.raddr];
    end
endmodule
`default_nettype wire

@@ rtl/core/sjfs_predict.sv @@
// Registered exponential-average prediction unit
`default_nettype none
module sjfs_predict
    import sjfs_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic [8:0]  i_w,
    input  wire logic [15:0] i_last,
    input  wire logic [23:0] i_pred,
    output logic [23:0]      o_p
);
    logic [8:0]  w;
    logic [33:0] a, b;
    logic [34:0] s;
    assign w = (i_w > 9'd256) ? 9'd256 : i_w;
    always_comb begin
        a = 34'(w) * 34'({i_last, 8'd0});
        b = 34'(9'd256 - w) * 34'(i_pred);
        s = 35'(a) + 35'(b);
    end
    always_ff @(posedge i_clk) begin
        o_p <= s[31:8];
    end
endmodule
`default_nettype wire

@@ tb/sv/sjf_preemptive_scheduler_core_test.sv @@
// Testbench for the SJF preemptive scheduler core: directed and random requests checked against a scoreboard
`timescale 1ns / 100ps
`default_nettype none
module sjf_preemptive_scheduler_core_test;
    import sjfs_pkg::*;

    class sched_scoreboard;
        logic [8:0]  weight;
        t_entry      ready_q[$];
        bit          run_valid[MaxCpus];
        logic [7:0]  run_pid[MaxCpus];
        logic [23:0] run_pred[MaxCpus];
        t_rsp        expected_rsps[$];
        int          errors;

        function new();
            weight = 9'd128;
            errors = 0;
            foreach (run_valid[i]) run_valid[i] = 0;
        endfunction

        function logic [23:0] predict_burst(logic [15:0] last, logic [23:0] prev);
            logic [63:0] w;
            logic [63:0] v;
            w = (weight > 9'd256) ? 64'd256 : 64'(weight);
            v = w * (64'(last) << 8) + (64'd256 - w) * 64'(prev);
            return v[31:8];
        endfunction

        function void show_cpu(int c, ref t_rsp r);
            if (run_valid[c]) begin
                r.assigned_valid = 1'b1;
                r.assigned_pid = run_pid[c];
                r.chosen_prediction = run_pred[c];
            end
        endfunction

        function void note_request(t_req q);
            t_rsp r;
            int best;
            logic [23:0] min_pred;
            logic [23:0] p;
            logic [23:0] used;
            logic [23:0] rem;
            t_entry e;
            logic [7:0] cpid;
            r = '0;
            if (q.op == OP_ENQ) begin
                if (ready_q.size() >= QueueDepth) r.queue_full = 1'b1;
                else begin
                    e.pid = q.pid; e.last = q.last_burst; e.pred = q.predicted_burst;
                    ready_q.push_back(e);
                end
            end else if (q.op == OP_SCH) begin
                best = -1;
                min_pred = SentinelQ;
                foreach (ready_q[i]) begin
                    p = predict_burst(ready_q[i].last, ready_q[i].pred);
                    if (p < min_pred) begin
                        min_pred = p; best = i;
                    end
                end
                if (best < 0) show_cpu(q.cpu, r);
                else begin
                    cpid = ready_q[best].pid;
                    if (run_valid[q.cpu]) begin
                        used = {q.elapsed, 8'd0};
                        rem = (run_pred[q.cpu] >= used) ? run_pred[q.cpu] - used : 24'd0;
                        if (rem <= min_pred) begin
                            show_cpu(q.cpu, r);
                            expected_rsps.push_back(r);
                            return;
                        end
                        ready_q.delete(best);
                        e.pid = run_pid[q.cpu]; e.last = q.elapsed; e.pred = rem;
                        ready_q.push_back(e);
                        r.preempted = 1'b1;
                        r.preempted_pid = run_pid[q.cpu];
                    end else ready_q.delete(best);
                    run_valid[q.cpu] = 1;
                    run_pid[q.cpu] = cpid;
                    run_pred[q.cpu] = min_pred;
                    show_cpu(q.cpu, r);
                end
            end else if (q.op == OP_REL) begin
                run_valid[q.cpu] = 0;
            end
            expected_rsps.push_back(r);
        endfunction

        function void check_response(t_rsp a);
            t_rsp x;
            if (expected_rsps.size() == 0) begin
                $display("%0t: unexpected response %h", $time, a);
                errors++;
                return;
            end
            x = expected_rsps.pop_front();
            if (a.assigned_valid !== x.assigned_valid)
                $display("%0t: assigned_valid exp %h act %h", $time, x.assigned_valid,
                         a.assigned_valid);
            if (a.assigned_pid !== x.assigned_pid)
                $display("%0t: assigned_pid exp %h act %h", $time, x.assigned_pid,
                         a.assigned_pid);
            if (a.preempted !== x.preempted)
                $display("%0t: preempted exp %h act %h", $time, x.preempted, a.preempted);
            if (a.preempted_pid !== x.preempted_pid)
                $display("%0t: preempted_pid exp %h act %h", $time, x.preempted_pid,
                         a.preempted_pid);
            if (a.chosen_prediction !== x.chosen_prediction)
                $display("%0t: chosen_prediction exp %h act %h", $time,
                         x.chosen_prediction, a.chosen_prediction);
            if (a.queue_full !== x.queue_full)
                $display("%0t: queue_full exp %h act %h", $time, x.queue_full, a.queue_full);
            if (a !== x) errors++;
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    t_req       req;
    logic       req_valid;
    logic       req_stall;
    t_rsp       rsp;
    logic       rsp_valid;
    logic       rsp_stall;
    logic       weight_we;
    logic [8:0] weight_data;
    sched_scoreboard sb;
    int burst_left;
    bit stall_mode;

    sjf_preemptive_scheduler_core uut (
        .i_clk(clk), .i_rst_n(rst_n), .i_req(req), .i_req_valid(req_valid),
        .o_req_stall(req_stall), .o_rsp(rsp), .o_rsp_valid(rsp_valid),
        .i_rsp_stall(rsp_stall), .i_decay_weight_we(weight_we),
        .i_decay_weight(weight_data)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        #50ms;
        $display("Simulation FAILED");
        $finish;
    end

    // receiver stall pattern, with quiet stretches
    always @(posedge clk) begin
        if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
        rsp_stall <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b0;
        if (rsp_valid && !rsp_stall) sb.check_response(rsp);
    end

    task automatic send_request(t_req q);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30);
            if (gap != 0) begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req <= q;
        req_valid <= 1'b1;
        do @(posedge clk); while (req_stall);
        sb.note_request(q);
    endtask

    task automatic drain_and_write(logic [8:0] w);
        req_valid <= 1'b0;
        while (sb.expected_rsps.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        weight_we <= 1'b1;
        weight_data <= w;
        @(posedge clk);
        weight_we <= 1'b0;
        sb.weight = w;
    endtask

    function automatic t_req rand_request(int mode);
        t_req q;
        int r;
        q = '0;
        q.pid = 8'($urandom_range(0, 255));
        q.cpu = 3'($urandom_range(0, 7));
        r = $urandom_range(0, 99);
        if (r < 45) q.op = OP_ENQ;
        else if (r < 85) q.op = OP_SCH;
        else if (r < 97) q.op = OP_REL;
        else q.op = 2'd3;
        if (mode == 0 || $urandom_range(0, 7) == 0) begin
            q.last_burst = 16'($urandom);
            q.predicted_burst = 24'($urandom);
            q.elapsed = 16'($urandom);
        end else begin
            q.last_burst = 16'($urandom_range(0, 1100));
            q.predicted_burst = 24'($urandom_range(0, 1100 * 256));
            q.elapsed = 16'($urandom_range(0, 600));
        end
        return q;
    endfunction

    initial begin
        t_req q;
        logic [8:0] weights[6];
        sb = new();
        rst_n = 1'b0;
        req = '0;
        req_valid = 1'b0;
        rsp_stall = 1'b0;
        stall_mode = 1'b0;
        weight_we = 1'b0;
        weight_data = 9'd0;
        burst_left = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty schedule, full table, extremes, bad op
        q = '0; q.op = OP_SCH; send_request(q);
        for (int i = 0; i < 17; i++) begin
            q = '0; q.op = OP_ENQ; q.pid = 8'(i * 15);
            q.last_burst = (i == 0) ? 16'hFFFF : 16'(i * 50);
            q.predicted_burst = (i == 1) ? 24'hFFFFFF : 24'(i * 3000);
            send_request(q);
        end
        q = '0; q.op = OP_SCH; q.cpu = 3'd7; send_request(q);
        q = '0; q.op = OP_SCH; q.cpu = 3'd7; q.elapsed = 16'hFFFF; send_request(q);
        q = '0; q.op = OP_SCH; q.cpu = 3'd7; send_request(q);
        q = '0; q.op = 2'd3; q.cpu = 3'd7; send_request(q);
        q = '0; q.op = OP_REL; q.cpu = 3'd7; send_request(q);
        q = '0; q.op = OP_SCH; q.cpu = 3'd7; send_request(q);

        weights = '{9'd0, 9'd256, 9'd511, 9'd1, 9'd200, 9'd128};
        foreach (weights[k]) begin
            drain_and_write(weights[k]);
            for (int n = 0; n < 280; n++) send_request(rand_request(k % 2 + (k > 3)));
        end

        req_valid <= 1'b0;
        while (sb.expected_rsps.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.errors == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end
endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+rtl/core
rtl/core/sjfs_pkg.sv
rtl/core/sjfs_ready_ram.sv
rtl/core/sjfs_predict.sv
rtl/core/sjf_preemptive_scheduler_core.sv
tb/sv/sjf_preemptive_scheduler_core_test.sv
